>>> sv/assert_macros.svh
// Assertion macros shared by the decoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bsfd_pkg.sv
// Shared types and constants for the byte-stuffed frame decoder.
package bsfd_pkg;

    localparam int HEADER_BYTES     = 4;
    localparam int MAX_DATA_DEFAULT = 256;
    localparam int QUEUE_DEPTH      = 2;

    // Framing bytes
    localparam logic [7:0] BYTE_START = 8'h7E;
    localparam logic [7:0] BYTE_STOP  = 8'h7D;
    localparam logic [7:0] BYTE_ESC   = 8'h7C;

    // Codes that follow an escape
    localparam logic [7:0] ESC_CODE_STOP  = 8'h01;
    localparam logic [7:0] ESC_CODE_START = 8'h02;
    localparam logic [7:0] ESC_CODE_ESC   = 8'h03;

    typedef enum logic [1:0] {
        CLS_PLAIN = 2'd0,
        CLS_START = 2'd1,
        CLS_STOP  = 2'd2,
        CLS_ESC   = 2'd3
    } byte_class_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_NO_START   = 4'd1,
        ERR_BAD_ESC    = 4'd2,
        ERR_STRAY      = 4'd3,
        ERR_TOO_LONG   = 4'd4,
        ERR_SHORT_HDR  = 4'd5,
        ERR_SIZE_OVER  = 4'd6,
        ERR_LEN_MISMATCH = 4'd7,
        ERR_NO_STOP    = 4'd8
    } err_t;

    // Classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
        logic        esc_ok;
        logic [7:0]  esc_data;
        logic        eob;
    } item_t;

endpackage

>>> sv/bsfd_front.sv
// Front end: classifies incoming bytes and buffers them in a two-entry queue.
`include "assert_macros.svh"

module bsfd_front import bsfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,   // end_of_buffer
    output logic       head_valid,
    output item_t      head,
    input  logic       pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          q_mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  q_count_reg, q_count_next;
    item_t          item;
    logic           push;

    // Byte classification and unescape lookup
    always_comb begin
        item.data     = s_tdata;
        item.eob      = s_tlast;
        item.cls      = CLS_PLAIN;
        item.esc_ok   = 1'b1;
        item.esc_data = 8'h00;
        unique case (s_tdata)
            BYTE_START: item.cls = CLS_START;
            BYTE_STOP:  item.cls = CLS_STOP;
            BYTE_ESC:   item.cls = CLS_ESC;
            default:    item.cls = CLS_PLAIN;
        endcase
        unique case (s_tdata)
            ESC_CODE_STOP:  item.esc_data = BYTE_STOP;
            ESC_CODE_START: item.esc_data = BYTE_START;
            ESC_CODE_ESC:   item.esc_data = BYTE_ESC;
            default:        item.esc_ok   = 1'b0;
        endcase
    end

    assign s_tready   = (q_count_reg != CW'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (q_count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        q_count_next = q_count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            q_count_next = q_count_reg + 1'b1;
        end else if (pop && !push) begin
            q_count_next = q_count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    `ASSERT_ALWAYS(a_q_no_overflow, q_count_reg <= CW'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_IMPLY(a_q_no_underflow, pop, q_count_reg != '0, "pop from empty queue")

endmodule

>>> sv/bsfd_back.sv
// Back end: frame state machine, header checks and the result register.
`include "assert_macros.svh"

module bsfd_back import bsfd_pkg::*; #(
    parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        head_valid,
    input  item_t       head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [7:0] data_byte, [16:8] frame_length, [20:17] error_code
    output logic [1:0]  m_tuser   // [1:0] kind
);

    localparam int LIMIT = HEADER_BYTES + MAX_DATA;
    localparam int CW    = $clog2(LIMIT + 1);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_IN    = 2'd1,
        PH_ESC   = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [15:0]    size_reg, size_next;
    logic           check_header_reg, check_header_next;
    logic           out_valid_reg, out_valid_next;
    kind_t          kind_reg, kind_next;
    logic [7:0]     data_reg, data_next;
    logic [8:0]     len_reg, len_next;
    err_t           err_reg, err_next;

    logic           have;
    logic           do_take;
    logic [7:0]     take_byte;
    err_t           stop_err;

    assign cfg_ready = 1'b1;
    assign pop       = head_valid && (!out_valid_reg || m_tready);

    // Header check applied at the stop byte
    always_comb begin
        stop_err = ERR_NONE;
        if (check_header_reg) begin
            if (count_reg < CW'(HEADER_BYTES)) begin
                stop_err = ERR_SHORT_HDR;
            end else if (size_reg > 16'(MAX_DATA)) begin
                stop_err = ERR_SIZE_OVER;
            end else if (17'(count_reg) != (17'(HEADER_BYTES) + {1'b0, size_reg})) begin
                stop_err = ERR_LEN_MISMATCH;
            end
        end
    end

    // Per-byte decode step
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        size_next  = size_reg;
        have       = 1'b0;
        kind_next  = KIND_DATA;
        data_next  = 8'h00;
        len_next   = 9'h000;
        err_next   = ERR_NONE;
        do_take    = 1'b0;
        take_byte  = head.data;

        if (pop) begin
            unique case (phase_reg)
                PH_START: begin
                    if (head.cls == CLS_START) begin
                        phase_next = PH_IN;
                        count_next = '0;
                        size_next  = '0;
                    end else begin
                        have       = 1'b1;
                        kind_next  = KIND_REJECT;
                        err_next   = ERR_NO_START;
                        phase_next = PH_DONE;
                    end
                end
                PH_IN: begin
                    case (head.cls)
                        CLS_ESC:   phase_next = PH_ESC;
                        CLS_START: begin
                            have       = 1'b1;
                            kind_next  = KIND_REJECT;
                            err_next   = ERR_STRAY;
                            phase_next = PH_DONE;
                        end
                        CLS_STOP: begin
                            have       = 1'b1;
                            phase_next = PH_DONE;
                            if (stop_err == ERR_NONE) begin
                                kind_next = KIND_ACCEPT;
                                len_next  = 9'(count_reg);
                            end else begin
                                kind_next = KIND_REJECT;
                                err_next  = stop_err;
                            end
                        end
                        default: do_take = 1'b1;
                    endcase
                end
                PH_ESC: begin
                    if (!head.esc_ok) begin
                        have       = 1'b1;
                        kind_next  = KIND_REJECT;
                        err_next   = ERR_BAD_ESC;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_IN;
                        do_take    = 1'b1;
                        take_byte  = head.esc_data;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            // Store one decoded byte, or fail on the length limit
            if (do_take) begin
                have = 1'b1;
                if (count_reg >= CW'(LIMIT)) begin
                    kind_next  = KIND_REJECT;
                    err_next   = ERR_TOO_LONG;
                    phase_next = PH_DONE;
                end else begin
                    if (count_reg == CW'(2)) begin
                        size_next[7:0] = take_byte;
                    end
                    if (count_reg == CW'(3)) begin
                        size_next[15:8] = take_byte;
                    end
                    count_next = count_reg + 1'b1;
                    kind_next  = KIND_DATA;
                    data_next  = take_byte;
                end
            end

            // Buffer end: an open frame turns into a missing-stop error
            if (head.eob) begin
                if (phase_next == PH_IN || phase_next == PH_ESC) begin
                    have      = 1'b1;
                    kind_next = KIND_REJECT;
                    data_next = 8'h00;
                    len_next  = 9'h000;
                    err_next  = ERR_NO_STOP;
                end
                phase_next = PH_START;
                count_next = '0;
                size_next  = '0;
            end
        end
    end

    assign check_header_next = (cfg_valid && cfg_ready) ? cfg_data : check_header_reg;

    // Output slot frees on a transfer; loads on a decode step with a result
    always_comb begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || m_tready) begin
            out_valid_next = pop && have;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_START;
            count_reg        <= '0;
            size_reg         <= '0;
            check_header_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            size_reg         <= size_next;
            check_header_reg <= check_header_next;
            out_valid_reg    <= out_valid_next;
        end
        if (pop && have) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            len_reg  <= len_next;
            err_reg  <= err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'b000, err_reg, len_reg, data_reg};

    `ASSERT_ALWAYS(a_count_limit, count_reg <= CW'(LIMIT), "decoded count beyond limit")
    `ASSERT_IMPLY(a_data_clean, out_valid_reg && kind_reg == KIND_DATA,
                  len_reg == 9'h000 && err_reg == ERR_NONE, "data result carries status fields")
    `ASSERT_NEXT(a_eob_restart, pop && head.eob, phase_reg == PH_START && count_reg == '0,
                 "buffer end did not restart framing")

endmodule

>>> sv/byte_stuffed_frame_decoder_top.sv
// Top level of the byte-stuffed frame decoder: front classifier, queue and back-end decoder.
// A byte transferred in is written to the queue; when the result register is free it is popped
// and decoded, and its result, if it has one, is registered there and shown on m_tvalid.
// Throughput: one byte per cycle sustained while m_tready does not hold off results; the two-entry
// queue and the result register let input and output stall independently.
// Reset: aresetn (synchronous, low) empties queue and result slot; framing restarts, check_header 1.
module byte_stuffed_frame_decoder_top import bsfd_pkg::*; #(
    parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [16:8] frame_length, [20:17] error_code
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // check_header
);

    logic  head_valid;
    item_t head;
    logic  pop;

    bsfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    bsfd_back #(
        .MAX_DATA (MAX_DATA)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

>>> tb/byte_stuffed_frame_decoder_top_test.sv
// Self-checking testbench for the byte-stuffed frame decoder: directed and random framed traffic vs predictor.
module byte_stuffed_frame_decoder_top_test import bsfd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_BYTES    = HEADER_BYTES + MAX_DATA_DEFAULT;
    localparam int HOLD_CYCLES  = 300;

    // One raw byte on the input stream
    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } wire_byte_t;

    // One result as the decoder should present it
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [8:0] len;
        err_t       err;
    } frame_result_t;

    typedef enum logic [1:0] {
        FR_HUNT,
        FR_BODY,
        FR_ESCAPED,
        FR_SKIP
    } frame_phase_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_NO_START,
        FAULT_BAD_ESC,
        FAULT_STRAY,
        FAULT_CUT,
        FAULT_NOISE
    } fault_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    // Predictor state
    frame_phase_t  fr_phase  = FR_HUNT;
    int unsigned   fr_count  = 0;
    logic [15:0]   fr_size   = '0;
    logic          hdr_check = 1'b1;
    frame_result_t expected_results[$];

    // Stimulus and bookkeeping
    wire_byte_t    byte_queue[$];
    wire_byte_t    next_byte;
    logic [7:0]    frame_body[$];
    frame_result_t want;
    int            items_queued  = 0;
    int            bytes_in      = 0;
    int            send_idle_pct = 22;
    int            recv_idle_pct = 49;
    int            hold_start_at = -1;
    int            hold_left     = 0;
    bit            hold_done     = 1'b0;
    int            stall_cycles  = 0;
    int            failures      = 0;
    int            data_seen     = 0;
    int            accepts_seen  = 0;
    int            rejects_seen  = 0;
    int            cycle_count   = 0;

    byte_stuffed_frame_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    // Status closes the frame; the rest of the buffer is skipped
    function automatic frame_result_t status_result(err_t err);
        frame_result_t r;
        r.kind = (err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
        r.data = '0;
        r.len  = (err == ERR_NONE) ? 9'(fr_count) : '0;
        r.err  = err;
        fr_phase = FR_SKIP;
        return r;
    endfunction

    // Decoded byte, plain or unescaped; header bytes 2 and 3 hold the size
    function automatic frame_result_t take_byte(logic [7:0] d);
        frame_result_t r;
        if (fr_count >= MAX_BYTES) return status_result(ERR_TOO_LONG);
        if (fr_count == 2) fr_size[7:0] = d;
        if (fr_count == 3) fr_size[15:8] = d;
        fr_count++;
        r.kind = KIND_DATA;
        r.data = d;
        r.len  = '0;
        r.err  = ERR_NONE;
        return r;
    endfunction

    function automatic frame_result_t close_frame();
        if (!hdr_check) return status_result(ERR_NONE);
        if (fr_count < HEADER_BYTES) return status_result(ERR_SHORT_HDR);
        if (fr_size > MAX_DATA_DEFAULT) return status_result(ERR_SIZE_OVER);
        if (fr_count != HEADER_BYTES + fr_size) return status_result(ERR_LEN_MISMATCH);
        return status_result(ERR_NONE);
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic eob);
        frame_result_t r;
        bit            got;
        logic [7:0]    d;
        got = 1'b0;
        case (fr_phase)
            FR_HUNT: begin
                if (b == BYTE_START) begin
                    fr_phase = FR_BODY;
                    fr_count = 0;
                    fr_size  = '0;
                end else begin
                    r   = status_result(ERR_NO_START);
                    got = 1'b1;
                end
            end
            FR_BODY: begin
                got = 1'b1;
                if (b == BYTE_ESC) begin
                    fr_phase = FR_ESCAPED;
                    got      = 1'b0;
                end else if (b == BYTE_START) begin
                    r = status_result(ERR_STRAY);
                end else if (b == BYTE_STOP) begin
                    r = close_frame();
                end else begin
                    r = take_byte(b);
                end
            end
            FR_ESCAPED: begin
                case (b)
                    ESC_CODE_STOP:  d = BYTE_STOP;
                    ESC_CODE_START: d = BYTE_START;
                    ESC_CODE_ESC:   d = BYTE_ESC;
                    default:        d = '0;
                endcase
                if (d == '0) begin
                    r = status_result(ERR_BAD_ESC);
                end else begin
                    fr_phase = FR_BODY;
                    r = take_byte(d);
                end
                got = 1'b1;
            end
            default: ;
        endcase
        // end of buffer: an open frame replaces any data result with no-stop
        if (eob) begin
            if (fr_phase == FR_BODY || fr_phase == FR_ESCAPED) begin
                r   = status_result(ERR_NO_STOP);
                got = 1'b1;
            end
            fr_phase = FR_HUNT;
            fr_count = 0;
            fr_size  = '0;
        end
        if (got) expected_results.push_back(r);
    endfunction

    // ---------------- stimulus helpers ----------------

    // Up to eight raw bytes given first-byte-high; the last one ends the buffer
    function automatic void queue_seq(logic [63:0] bytes, int n);
        for (int i = 0; i < n; i++) begin
            byte_queue.push_back('{bytes[8*(n-1-i) +: 8], i == n - 1});
            items_queued++;
        end
    endfunction

    // Framing bytes show up often so escapes are well exercised
    function automatic logic [7:0] random_payload_byte();
        case ($urandom_range(0, 7))
            0:       return BYTE_START;
            1:       return BYTE_STOP;
            2:       return BYTE_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Stuff frame_body into a buffer, apply a fault, queue it
    function automatic void queue_frame(fault_t fault);
        logic [7:0] raw[$];
        logic [7:0] code;
        int         pos;
        raw.push_back(BYTE_START);
        foreach (frame_body[i]) begin
            case (frame_body[i])
                BYTE_STOP:  begin raw.push_back(BYTE_ESC); raw.push_back(ESC_CODE_STOP);  end
                BYTE_START: begin raw.push_back(BYTE_ESC); raw.push_back(ESC_CODE_START); end
                BYTE_ESC:   begin raw.push_back(BYTE_ESC); raw.push_back(ESC_CODE_ESC);   end
                default:    raw.push_back(frame_body[i]);
            endcase
        end
        raw.push_back(BYTE_STOP);
        case (fault)
            FAULT_NO_START: void'(raw.pop_front());
            FAULT_BAD_ESC: begin
                do code = 8'($urandom_range(0, 255));
                while (code == ESC_CODE_STOP || code == ESC_CODE_START || code == ESC_CODE_ESC);
                pos = $urandom_range(1, raw.size() - 1);
                raw.insert(pos, code);
                raw.insert(pos, BYTE_ESC);
            end
            FAULT_STRAY: raw.insert($urandom_range(1, raw.size() - 1), BYTE_START);
            FAULT_CUT: begin
                // buffer ends before the stop, possibly right after an escape
                pos = $urandom_range(1, raw.size() - 1);
                while (raw.size() > pos) void'(raw.pop_back());
            end
            FAULT_NOISE: begin
                raw.delete();
                repeat ($urandom_range(1, 6)) raw.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        // trailing bytes after the status are ignored by the block
        if (fault != FAULT_CUT && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) raw.push_back(random_payload_byte());
        foreach (raw[i]) byte_queue.push_back('{raw[i], i == raw.size() - 1});
        items_queued += raw.size();
    endfunction

    // Mostly well-formed frames with random content, some broken ones
    function automatic void random_frame();
        int          roll;
        int          n;
        logic [15:0] size;
        fault_t      fault;
        roll = $urandom_range(0, 99);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        size = 16'(n);
        if (roll < 10) size = size ^ (16'h1 << $urandom_range(0, 15));
        frame_body.delete();
        if (roll >= 10 && roll < 16) begin
            repeat ($urandom_range(0, HEADER_BYTES - 1)) frame_body.push_back(random_payload_byte());
        end else begin
            frame_body.push_back(random_payload_byte());
            frame_body.push_back(random_payload_byte());
            frame_body.push_back(size[7:0]);
            frame_body.push_back(size[15:8]);
            repeat (n) frame_body.push_back(random_payload_byte());
        end
        if (roll < 16)      fault = FAULT_NONE;
        else if (roll < 22) fault = FAULT_NO_START;
        else if (roll < 28) fault = FAULT_BAD_ESC;
        else if (roll < 34) fault = FAULT_STRAY;
        else if (roll < 42) fault = FAULT_CUT;
        else if (roll < 47) fault = FAULT_NOISE;
        else                fault = FAULT_NONE;
        queue_frame(fault);
    endfunction

    task automatic fill_random(int count);
        int target;
        target = items_queued + count;
        while (items_queued < target) random_frame();
    endtask

    // Wait until every byte is sent and every result has come, then let the pipe settle
    task automatic drain();
        while (byte_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_check_header(logic value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hdr_check = value;
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_byte = byte_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.value;
                s_tlast  <= next_byte.eob;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, started once a set number of bytes went in
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (s_tvalid && !s_tready) stall_cycles <= stall_cycles + 1;
        end else if (!hold_done && bytes_in == hold_start_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    // Input transfers feed the predictor first, so a same-edge result still finds its entry
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_in <= bytes_in + 1;
            end
            if (m_tvalid && m_tready) begin
                case (m_tuser)
                    KIND_DATA:   data_seen++;
                    KIND_ACCEPT: accepts_seen++;
                    default:     rejects_seen++;
                endcase
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: kind %0d data %02h len %0d err %0d",
                                 m_tuser, m_tdata[7:0], m_tdata[16:8], m_tdata[20:17]);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser != want.kind || m_tdata[7:0] != want.data ||
                        m_tdata[16:8] != want.len || m_tdata[20:17] != want.err) begin
                        failures++;
                        if (failures <= 10)
                            $display({"mismatch (exp/act): kind %0d/%0d data %02h/%02h ",
                                      "len %0d/%0d err %0d/%0d"},
                                     want.kind, m_tuser, want.data, m_tdata[7:0],
                                     want.len, m_tdata[16:8], want.err, m_tdata[20:17]);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("byte_stuffed_frame_decoder_top_test NOT OK");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed buffers with header checking on
        write_check_header(1'b1);
        // escapes for stop and start, zero-size header: accepted with length 4
        queue_seq({BYTE_START, BYTE_ESC, ESC_CODE_STOP, BYTE_ESC, ESC_CODE_START,
                   8'h00, 8'h00, BYTE_STOP}, 8);
        // missing start
        queue_seq({8'hFF}, 1);
        // escaped escape byte, then a bad escape code
        queue_seq({BYTE_START, BYTE_ESC, ESC_CODE_ESC, BYTE_ESC, 8'h00}, 5);
        // stray start, the following byte is skipped
        queue_seq({BYTE_START, BYTE_START, 8'h00}, 3);
        // declared size 257 is over the maximum
        queue_seq({BYTE_START, 8'h00, 8'h00, 8'h01, 8'h01, BYTE_STOP}, 6);
        // buffer ends with an escape pending
        queue_seq({BYTE_START, BYTE_ESC}, 2);
        // header too short
        queue_seq({BYTE_START, 8'h80, BYTE_STOP}, 3);
        drain();

        // empty frame is accepted when checking is off
        write_check_header(1'b0);
        queue_seq({BYTE_START, BYTE_STOP}, 2);
        drain();

        // sender idles lightly, receiver heavily; checking on
        write_check_header(1'b1);
        fill_random(120);
        drain();

        // roles swapped, checking off; an escaped byte crosses the length limit
        send_idle_pct = 49;
        recv_idle_pct = 22;
        write_check_header(1'b0);
        frame_body.delete();
        repeat (MAX_BYTES) frame_body.push_back(8'($urandom_range(0, 255)));
        frame_body.push_back(BYTE_START);
        queue_frame(FAULT_NONE);
        fill_random(70);
        drain();

        // no idling, checking on, longest legal frame, receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_check_header(1'b1);
        hold_start_at = bytes_in + 20;
        frame_body.delete();
        frame_body.push_back(8'($urandom_range(0, 255)));
        frame_body.push_back(8'($urandom_range(0, 255)));
        frame_body.push_back(8'(MAX_DATA_DEFAULT));
        frame_body.push_back(8'(MAX_DATA_DEFAULT >> 8));
        repeat (MAX_DATA_DEFAULT) frame_body.push_back(8'($urandom_range(0, 255)));
        queue_frame(FAULT_NONE);
        fill_random(70);
        drain();

        failures += expected_results.size();
        $display("%0d bytes in; %0d data bytes, %0d frames accepted, %0d rejected",
                 bytes_in, data_seen, accepts_seen, rejects_seen);
        $display("header check on and off, idling both sides, %0d input stall cycles in hold-off",
                 stall_cycles);
        if (failures == 0) begin
            $display("byte_stuffed_frame_decoder_top_test OK");
        end else begin
            $display("byte_stuffed_frame_decoder_top_test NOT OK");
        end
        $finish;
    end

endmodule
